// ----- sv/sil_pkg.sv -----
// Shared constants and types for the sorted insertion list.
package sil_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int VALUE_W      = 32;
  localparam int INDEX_W      = 6;
  localparam int OUT_TDATA_W  = 40;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_CMP,
    ST_PUT,
    ST_EMIT
  } sil_state_t;

endpackage

// ----- sv/sil_ram.sv -----
// Generic simple dual-port RAM with registered read and read enable.
module sil_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- sv/sorted_insert_list.sv -----
// Sorted insertion list: keeps up to CAPACITY signed Q16.16 values in ascending order.
// Sequence: each item is accepted, then a read is issued (held while the previous last result
//   waits), then one compare step per larger entry shifted up plus one step to place the value,
//   then the whole list is streamed out; an empty list skips the issue and compare steps. A full
//   list drops the value and streams the list unchanged. Output stalls hold the streaming.
// Throughput: one transaction at a time. Reset: synchronous, clears the count and control
//   state; the RAM is not cleared, since only entries below the count are ever read.
module sorted_insert_list
  import sil_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // Input stream
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [VALUE_W-1:0]     s_tdata,   // [31:0] new_value
  // Output stream
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // [31:0] element_value, [37:32] element_index
  output logic                   m_tlast,   // last_of_run
  output logic                   m_tuser    // value_dropped
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  sil_state_t state, state_next;

  logic [CW-1:0]      count, count_next;
  logic [AW-1:0]      pos, pos_next;
  logic [AW-1:0]      k, k_next;
  logic [VALUE_W-1:0] val;
  logic               dropped;

  // Output side bookkeeping; the RAM read register carries element_value
  logic               out_valid;
  logic [AW-1:0]      out_index;
  logic               out_last;
  logic               out_dropped;

  logic               rd_en, wr_en;
  logic [AW-1:0]      rd_addr, wr_addr;
  logic [VALUE_W-1:0] wr_data, rd_data;
  logic               greater, emit_last, out_free, accept;

  sil_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !out_valid || m_tready;
  assign greater  = $signed(rd_data) > $signed(val);
  assign emit_last = ((CW'(k) + CW'(1)) == count);

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(OUT_TDATA_W - VALUE_W - INDEX_W){1'b0}}, INDEX_W'(out_index), rd_data};
  assign m_tlast  = out_last;
  assign m_tuser  = out_dropped;

  // Sequencer: shift larger entries up from the top, drop the new value in, then stream out
  always_comb begin
    state_next = state;
    count_next = count;
    pos_next   = pos;
    k_next     = k;
    rd_en      = 1'b0;
    rd_addr    = k;
    wr_en      = 1'b0;
    wr_addr    = pos;
    wr_data    = val;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          k_next   = '0;
          pos_next = AW'(count);
          if (count == CW'(CAPACITY)) begin
            state_next = ST_EMIT;
          end else if (count == '0) begin
            state_next = ST_PUT;
          end else begin
            state_next = ST_ISSUE;
          end
        end
      end
      ST_ISSUE: begin
        // hold until the last result of the previous transaction has left the read register
        if (!out_valid) begin
          rd_en      = 1'b1;
          rd_addr    = pos - AW'(1);
          state_next = ST_CMP;
        end
      end
      ST_CMP: begin
        if (greater) begin
          wr_en    = 1'b1;
          wr_data  = rd_data;
          pos_next = pos - AW'(1);
          if (pos == AW'(1)) begin
            state_next = ST_PUT;
          end else begin
            rd_en   = 1'b1;
            rd_addr = pos - AW'(2);
          end
        end else begin
          wr_en      = 1'b1;
          count_next = count + CW'(1);
          state_next = ST_EMIT;
        end
      end
      ST_PUT: begin
        wr_en      = 1'b1;
        count_next = count + CW'(1);
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        // advance one entry whenever the output register is free or being taken
        if (out_free) begin
          rd_en   = 1'b1;
          rd_addr = k;
          k_next  = k + AW'(1);
          if (emit_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (state == ST_EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pos <= pos_next;
    k   <= k_next;
    if (accept) begin
      val     <= s_tdata;
      dropped <= (count == CW'(CAPACITY));
    end
    if (state == ST_EMIT && out_free) begin
      out_index   <= k;
      out_last    <= emit_last;
      out_dropped <= dropped;
    end
  end

endmodule
